// ===== src/abs_pkg.sv =====
package abs_pkg;

	// shared datapath width: 32-bit time plus carry and sign
	localparam int ALU_W = 34;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ENDPOINTS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_FLOOR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_CAP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_UNIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_SHIFT_CAP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT     = 3'd5;

	// register reset values
	localparam logic [3:0]  RST_NUM_ENDPOINTS     = 4'd1;
	localparam logic [11:0] RST_INTERVAL_FLOOR    = 12'd30;
	localparam logic [15:0] RST_INTERVAL_CAP      = 16'd3600;
	localparam logic [7:0]  RST_BACKOFF_UNIT      = 8'd5;
	localparam logic [3:0]  RST_BACKOFF_SHIFT_CAP = 4'd10;
	localparam logic [3:0]  RST_FAILURE_LIMIT     = 4'd7;

	// item actions
	localparam logic [1:0] ACT_SUCCESS = 2'd0;
	localparam logic [1:0] ACT_FAILURE = 2'd1;
	localparam logic [1:0] ACT_ROTATE  = 2'd2;
	localparam logic [1:0] ACT_QUERY   = 2'd3;

	// floor(x / 5) for 16-bit x as (x * 0xCCCD) >> 18
	localparam logic [32:0] JIT_RECIP = 33'h0CCCD;
	localparam int JIT_SHIFT = 18;

	// failure count saturation
	localparam logic [3:0] FAIL_MAX = 4'd15;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} alu_flags_t;

endpackage

// ===== src/abs_alu.sv =====
module abs_alu (
	input  abs_pkg::alu_op_t            op,
	input  logic signed [abs_pkg::ALU_W-1:0] a,
	input  logic signed [abs_pkg::ALU_W-1:0] b,
	output logic signed [abs_pkg::ALU_W-1:0] sum,
	output abs_pkg::alu_flags_t         flags
);

	// one adder serves add, subtract and compare
	always_comb begin
		if (op == abs_pkg::ALU_SUB) begin
			sum = a - b;
		end else begin
			sum = a + b;
		end
		flags.neg  = sum[abs_pkg::ALU_W-1];
		flags.zero = (sum == '0);
	end

endmodule

// ===== src/announce_backoff_scheduler_unit.sv =====
// Retry scheduler for a rotating set of announce endpoints.
// Input channel (in_valid/in_ready) carries one beat per event: success,
// failure, rotate or query, with the current time, the reported intervals
// and a signed jitter draw. Output channel (out_valid/out_ready) returns one
// beat per input beat: the current endpoint's state and whether any endpoint
// in use may announce now.
// Configuration is written through cfg_we/cfg_index/cfg_data only while
// idle, a rule for the user that the block itself does not enforce.
// A beat is taken in idle; the sequencer then runs the shared adder step by
// step: failure fetches, shifts, floors, caps and adds, success floors,
// caps, clamps the jitter, steps and adds, and both write the entry; every
// action ends with the scan, a registered table read and a compare per endpoint.
// Reset clears all failure counts, disabled and scheduled flags, the current
// endpoint and working registers and loads configuration defaults; the
// schedule memory stays uncleared, as an entry counts only once scheduled.
// A finished result sits in the output register; the next beat may be taken
// while it waits, and the sequencer holds before the following result until
// the receiver takes the pending one.
module announce_backoff_scheduler_unit #(
	parameter int MAX_ENDPOINTS = 8,
	parameter int TIME_BITS     = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [abs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [abs_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic [31:0]                      now_seconds,
	input  logic [31:0]                      interval,
	input  logic [31:0]                      min_interval,
	input  logic                             has_min_interval,
	input  logic signed [10:0]               jitter_draw,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       current_index,
	output logic                             current_can_announce,
	output logic                             any_available,
	output logic [3:0]                       current_failures,
	output logic                             current_disabled,
	output logic [31:0]                      current_next_allowed
);

	localparam int W  = abs_pkg::ALU_W;
	localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int IW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
	localparam int CW = $clog2(MAX_ENDPOINTS + 1);
	localparam logic [63:0] LIM64 = (64'd1 << TW) - 64'd1;
	localparam logic [TW-1:0] LIM = LIM64[TW-1:0];
	localparam int JIT_HI = abs_pkg::JIT_SHIFT + 13;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_SHIFT,
		S_FLOOR,
		S_CAP,
		S_JIT,
		S_DHI,
		S_DLO,
		S_STEP,
		S_ADD,
		S_WR,
		S_RD,
		S_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [3:0] fc;
		logic       dis;
		logic       sched;
	} entry_t;

	// configuration registers
	logic [3:0]  num_q;
	logic [11:0] floor_q;
	logic [15:0] cap_q;
	logic [7:0]  unit_q;
	logic [3:0]  shcap_q;
	logic [3:0]  limit_q;

	// per-endpoint state
	logic [3:0]    fc_arr_q    [MAX_ENDPOINTS];
	logic          dis_arr_q   [MAX_ENDPOINTS];
	logic          sched_arr_q [MAX_ENDPOINTS];
	logic [TW-1:0] na_mem      [MAX_ENDPOINTS];
	logic [IW-1:0] slot_q;

	// sequencer and datapath
	state_t               st_q;
	logic [1:0]           act_q;
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        scan_q;
	logic [TW-1:0]        now_q;
	logic signed [W-1:0]  acc_q;
	logic [13:0]          j_q;
	logic signed [14:0]   draw_q;
	logic [TW-1:0]        next_q;
	logic [3:0]           fc_new_q;
	logic                 dis_new_q;
	logic                 any_q;

	// current endpoint capture during the scan
	logic                 cur_can_q;
	logic [3:0]           cur_fc_q;
	logic                 cur_dis_q;
	logic [31:0]          cur_na_q;

	// registered reads
	logic [IW-1:0]        rd_addr;
	entry_t               ent_rd_q;
	logic [TW-1:0]        na_rd_q;

	// output register
	logic                 out_valid_q;
	logic [2:0]           out_idx_q;
	logic                 out_can_q;
	logic                 out_any_q;
	logic [3:0]           out_fc_q;
	logic                 out_dis_q;
	logic [31:0]          out_na_q;

	// shared unit
	abs_pkg::alu_op_t     alu_op;
	logic signed [W-1:0]  alu_a;
	logic signed [W-1:0]  alu_b;
	logic signed [W-1:0]  alu_sum;
	abs_pkg::alu_flags_t  alu_fl;

	abs_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.sum   (alu_sum),
		.flags (alu_fl)
	);

	// endpoint count in use and current slot for an incoming beat
	logic [CW-1:0] n_c;
	logic [IW-1:0] slot_fix;
	logic [IW-1:0] slot_rot;
	logic [31:0]   now_clamp;
	logic          scan_last;
	logic          avail;
	logic [32:0]   jit_prod;
	logic [3:0]    fc_inc;
	logic [3:0]    sh;
	logic [22:0]   shifted;

	always_comb begin
		if (num_q == 4'd0) begin
			n_c = CW'(1);
		end else if (32'(num_q) > MAX_ENDPOINTS) begin
			n_c = CW'(MAX_ENDPOINTS);
		end else begin
			n_c = CW'(num_q);
		end
		slot_fix = (32'(slot_q) >= 32'(n_c)) ? '0 : slot_q;
		slot_rot = (32'(slot_fix) + 32'd1 == 32'(n_c)) ? '0 : IW'(32'(slot_fix) + 32'd1);
		now_clamp = (now_seconds > LIM64[31:0]) ? LIM64[31:0] : now_seconds;
		scan_last = (32'(scan_q) + 32'd1 == 32'(n_c));
		avail = !ent_rd_q.dis && (!ent_rd_q.sched || !alu_fl.neg);
		jit_prod = 33'(acc_q[15:0]) * abs_pkg::JIT_RECIP;
		fc_inc = (ent_rd_q.fc == abs_pkg::FAIL_MAX) ? abs_pkg::FAIL_MAX : ent_rd_q.fc + 4'd1;
		sh = (fc_inc > shcap_q) ? shcap_q : fc_inc;
		shifted = 23'(unit_q) << sh;
	end

	// operand selection for the shared unit
	always_comb begin
		alu_op = abs_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (st_q)
			S_FLOOR: begin
				alu_op = abs_pkg::ALU_SUB;
				alu_a  = acc_q;
				alu_b  = W'(floor_q);
			end
			S_CAP: begin
				alu_op = abs_pkg::ALU_SUB;
				alu_a  = W'(cap_q);
				alu_b  = acc_q;
			end
			S_DHI: begin
				alu_op = abs_pkg::ALU_SUB;
				alu_a  = W'(draw_q);
				alu_b  = W'(j_q);
			end
			S_DLO: begin
				alu_a = W'(draw_q);
				alu_b = W'(j_q);
			end
			S_STEP: begin
				alu_a = acc_q;
				alu_b = W'(draw_q);
			end
			S_ADD: begin
				alu_a = W'(now_q);
				alu_b = acc_q;
			end
			S_CMP: begin
				alu_op = abs_pkg::ALU_SUB;
				alu_a  = W'(now_q);
				alu_b  = W'(na_rd_q);
			end
			default: begin
				alu_op = abs_pkg::ALU_ADD;
			end
		endcase
	end

	// one read address for the endpoint table
	assign rd_addr = (st_q == S_RD) ? scan_q : k_q;

	always_ff @(posedge clk) begin
		ent_rd_q.fc    <= fc_arr_q[rd_addr];
		ent_rd_q.dis   <= dis_arr_q[rd_addr];
		ent_rd_q.sched <= sched_arr_q[rd_addr];
		na_rd_q        <= na_mem[rd_addr];
	end

	// schedule memory write
	always_ff @(posedge clk) begin
		if (st_q == S_WR && act_q != abs_pkg::ACT_ROTATE && act_q != abs_pkg::ACT_QUERY) begin
			na_mem[k_q] <= next_q;
		end
	end

	// endpoint flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENDPOINTS; i++) begin
				fc_arr_q[i]    <= '0;
				dis_arr_q[i]   <= 1'b0;
				sched_arr_q[i] <= 1'b0;
			end
		end else if (st_q == S_WR) begin
			if (act_q == abs_pkg::ACT_SUCCESS) begin
				fc_arr_q[k_q]    <= '0;
				sched_arr_q[k_q] <= 1'b1;
			end else if (act_q == abs_pkg::ACT_FAILURE) begin
				fc_arr_q[k_q]    <= fc_new_q;
				dis_arr_q[k_q]   <= dis_new_q;
				sched_arr_q[k_q] <= 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= abs_pkg::RST_NUM_ENDPOINTS;
			floor_q <= abs_pkg::RST_INTERVAL_FLOOR;
			cap_q   <= abs_pkg::RST_INTERVAL_CAP;
			unit_q  <= abs_pkg::RST_BACKOFF_UNIT;
			shcap_q <= abs_pkg::RST_BACKOFF_SHIFT_CAP;
			limit_q <= abs_pkg::RST_FAILURE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				abs_pkg::REG_NUM_ENDPOINTS:     num_q   <= cfg_data[3:0];
				abs_pkg::REG_INTERVAL_FLOOR:    floor_q <= cfg_data[11:0];
				abs_pkg::REG_INTERVAL_CAP:      cap_q   <= cfg_data[15:0];
				abs_pkg::REG_BACKOFF_UNIT:      unit_q  <= cfg_data[7:0];
				abs_pkg::REG_BACKOFF_SHIFT_CAP: shcap_q <= cfg_data[3:0];
				abs_pkg::REG_FAILURE_LIMIT:     limit_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			act_q       <= abs_pkg::ACT_QUERY;
			slot_q      <= '0;
			k_q         <= '0;
			scan_q      <= '0;
			now_q       <= '0;
			acc_q       <= '0;
			j_q         <= '0;
			draw_q      <= '0;
			next_q      <= '0;
			fc_new_q    <= '0;
			dis_new_q   <= 1'b0;
			any_q       <= 1'b0;
			cur_can_q   <= 1'b0;
			cur_fc_q    <= '0;
			cur_dis_q   <= 1'b0;
			cur_na_q    <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_can_q   <= 1'b0;
			out_any_q   <= 1'b0;
			out_fc_q    <= '0;
			out_dis_q   <= 1'b0;
			out_na_q    <= '0;
		end else begin
			// result beat taken with no new result behind it
			if (out_valid_q && out_ready && st_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q  <= action;
						now_q  <= now_clamp[TW-1:0];
						acc_q  <= W'(has_min_interval ? min_interval : interval);
						draw_q <= 15'(jitter_draw);
						scan_q <= '0;
						any_q  <= 1'b0;
						if (action == abs_pkg::ACT_ROTATE) begin
							slot_q <= slot_rot;
							k_q    <= slot_rot;
						end else begin
							slot_q <= slot_fix;
							k_q    <= slot_fix;
						end
						case (action)
							abs_pkg::ACT_SUCCESS: st_q <= S_FLOOR;
							abs_pkg::ACT_FAILURE: st_q <= S_FETCH;
							default:              st_q <= S_RD;
						endcase
					end
				end
				S_FETCH: begin
					st_q <= S_SHIFT;
				end
				// saturating count and exponential backoff
				S_SHIFT: begin
					fc_new_q  <= fc_inc;
					dis_new_q <= ent_rd_q.dis | (fc_inc > limit_q);
					acc_q     <= W'(shifted);
					st_q      <= S_FLOOR;
				end
				// raise to the floor
				S_FLOOR: begin
					if (alu_fl.neg) begin
						acc_q <= W'(floor_q);
					end
					st_q <= S_CAP;
				end
				// limit to the cap
				S_CAP: begin
					if (alu_fl.neg) begin
						acc_q <= W'(cap_q);
					end
					st_q <= (act_q == abs_pkg::ACT_SUCCESS) ? S_JIT : S_ADD;
				end
				// allowed jitter is a fifth of the interval
				S_JIT: begin
					j_q  <= jit_prod[JIT_HI:abs_pkg::JIT_SHIFT];
					st_q <= S_DHI;
				end
				S_DHI: begin
					if (!alu_fl.neg && !alu_fl.zero) begin
						draw_q <= 15'(j_q);
					end
					st_q <= S_DLO;
				end
				S_DLO: begin
					if (alu_fl.neg) begin
						draw_q <= -15'(j_q);
					end
					st_q <= S_STEP;
				end
				// jittered step, at least one second
				S_STEP: begin
					if (alu_fl.neg || alu_fl.zero) begin
						acc_q <= W'(1);
					end else begin
						acc_q <= alu_sum;
					end
					st_q <= S_ADD;
				end
				// saturating time sum
				S_ADD: begin
					if (|alu_sum[W-1:TW]) begin
						next_q <= LIM;
					end else begin
						next_q <= alu_sum[TW-1:0];
					end
					st_q <= S_WR;
				end
				S_WR: begin
					st_q <= S_RD;
				end
				S_RD: begin
					st_q <= S_CMP;
				end
				// availability of one endpoint
				S_CMP: begin
					if (avail) begin
						any_q <= 1'b1;
					end
					if (scan_q == k_q) begin
						cur_can_q <= avail;
						cur_fc_q  <= ent_rd_q.fc;
						cur_dis_q <= ent_rd_q.dis;
						cur_na_q  <= ent_rd_q.sched ? 32'(na_rd_q) : '0;
					end
					if (scan_last) begin
						st_q <= S_DONE;
					end else begin
						scan_q <= scan_q + IW'(1);
						st_q   <= S_RD;
					end
				end
				// hand over once the output register is free
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= 3'(k_q);
						out_can_q   <= cur_can_q;
						out_any_q   <= any_q;
						out_fc_q    <= cur_fc_q;
						out_dis_q   <= cur_dis_q;
						out_na_q    <= cur_na_q;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready             = (st_q == S_IDLE);
	assign out_valid            = out_valid_q;
	assign current_index        = out_idx_q;
	assign current_can_announce = out_can_q;
	assign any_available        = out_any_q;
	assign current_failures     = out_fc_q;
	assign current_disabled     = out_dis_q;
	assign current_next_allowed = out_na_q;

endmodule

// ===== sim/announce_backoff_checker.sv =====
module announce_backoff_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [abs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [31:0]                    now_seconds,
	input  logic [31:0]                    interval,
	input  logic [31:0]                    min_interval,
	input  logic                           has_min_interval,
	input  logic signed [10:0]             jitter_draw,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [2:0]                     current_index,
	input  logic                           current_can_announce,
	input  logic                           any_available,
	input  logic [3:0]                     current_failures,
	input  logic                           current_disabled,
	input  logic [31:0]                    current_next_allowed,
	output int                             mismatches,
	output int                             reports_received
);

	localparam int SLOTS = 8;

	typedef struct packed {
		logic [2:0]  index;
		logic        can_announce;
		logic        any_avail;
		logic [3:0]  failures;
		logic        disabled;
		logic [31:0] next_allowed;
	} endpoint_report_t;

	// register copies
	logic [3:0]  num_in_use_reg;
	logic [11:0] floor_reg;
	logic [15:0] cap_reg;
	logic [7:0]  unit_reg;
	logic [3:0]  shift_cap_reg;
	logic [3:0]  fail_limit_reg;

	// per-endpoint retry state
	logic [3:0]  fail_cnt  [SLOTS];
	logic        disabled  [SLOTS];
	logic        scheduled [SLOTS];
	logic [31:0] due_time  [SLOTS];
	logic [2:0]  cur_slot;

	endpoint_report_t expected_reports [$];

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [31:0] span);
		logic [32:0] sum;
		sum = {1'b0, base} + {1'b0, span};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// floor first, then cap, so the cap wins when they cross
	function automatic logic [31:0] clamp_span(input logic [31:0] t);
		logic [31:0] r;
		r = t;
		if (r < {20'd0, floor_reg}) r = {20'd0, floor_reg};
		if (r > {16'd0, cap_reg}) r = {16'd0, cap_reg};
		return r;
	endfunction

	function automatic logic may_announce(input int slot, input logic [31:0] now);
		return !disabled[slot] && (!scheduled[slot] || now >= due_time[slot]);
	endfunction

	// apply one event to the endpoint table and build the report it yields
	function automatic endpoint_report_t advance_endpoint(
		input logic [1:0]         act,
		input logic [31:0]        now,
		input logic [31:0]        ivl,
		input logic [31:0]        mivl,
		input logic               use_min,
		input logic signed [10:0] draw
	);
		endpoint_report_t r;
		int in_use;
		int k;
		int d;
		int j;
		int off;
		int stp;
		logic [3:0] sh;
		logic any;

		in_use = (num_in_use_reg == 4'd0) ? 1 :
			(num_in_use_reg > SLOTS) ? SLOTS : int'(num_in_use_reg);
		if (cur_slot >= in_use) cur_slot = 3'd0;
		k = cur_slot;

		case (act)
			abs_pkg::ACT_SUCCESS: begin
				d = int'(clamp_span(use_min ? mivl : ivl));
				j = d / 5;
				off = draw;
				if (off > j) off = j;
				if (off < -j) off = -j;
				stp = d + off;
				if (stp < 1) stp = 1;
				due_time[k] = sat_add(now, 32'(stp));
				scheduled[k] = 1'b1;
				fail_cnt[k] = 4'd0;
			end
			abs_pkg::ACT_FAILURE: begin
				if (fail_cnt[k] != abs_pkg::FAIL_MAX) fail_cnt[k] = fail_cnt[k] + 4'd1;
				sh = (fail_cnt[k] > shift_cap_reg) ? shift_cap_reg : fail_cnt[k];
				due_time[k] = sat_add(now, clamp_span({24'd0, unit_reg} << sh));
				scheduled[k] = 1'b1;
				if (fail_cnt[k] > fail_limit_reg) disabled[k] = 1'b1;
			end
			abs_pkg::ACT_ROTATE: begin
				cur_slot = 3'((k + 1) % in_use);
				k = cur_slot;
			end
			abs_pkg::ACT_QUERY: ;
			default: ;
		endcase

		// availability scan over the endpoints in use
		any = 1'b0;
		for (int i = 0; i < in_use; i++)
			if (may_announce(i, now)) any = 1'b1;

		r.index        = 3'(k);
		r.can_announce = may_announce(k, now);
		r.any_avail    = any;
		r.failures     = fail_cnt[k];
		r.disabled     = disabled[k];
		r.next_allowed = scheduled[k] ? due_time[k] : 32'd0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		endpoint_report_t want;
		if (!arst_n) begin
			num_in_use_reg = abs_pkg::RST_NUM_ENDPOINTS;
			floor_reg      = abs_pkg::RST_INTERVAL_FLOOR;
			cap_reg        = abs_pkg::RST_INTERVAL_CAP;
			unit_reg       = abs_pkg::RST_BACKOFF_UNIT;
			shift_cap_reg  = abs_pkg::RST_BACKOFF_SHIFT_CAP;
			fail_limit_reg = abs_pkg::RST_FAILURE_LIMIT;
			for (int i = 0; i < SLOTS; i++) begin
				fail_cnt[i]  = 4'd0;
				disabled[i]  = 1'b0;
				scheduled[i] = 1'b0;
			end
			cur_slot = 3'd0;
			expected_reports.delete();
			mismatches = 0;
			reports_received = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					abs_pkg::REG_NUM_ENDPOINTS:     num_in_use_reg = cfg_data[3:0];
					abs_pkg::REG_INTERVAL_FLOOR:    floor_reg      = cfg_data[11:0];
					abs_pkg::REG_INTERVAL_CAP:      cap_reg        = cfg_data[15:0];
					abs_pkg::REG_BACKOFF_UNIT:      unit_reg       = cfg_data[7:0];
					abs_pkg::REG_BACKOFF_SHIFT_CAP: shift_cap_reg  = cfg_data[3:0];
					abs_pkg::REG_FAILURE_LIMIT:     fail_limit_reg = cfg_data[3:0];
					default: ;
				endcase
			end

			// result beat against the oldest expectation
			if (out_valid && out_ready) begin
				reports_received++;
				if (expected_reports.size() == 0) begin
					flag_mismatch("result beat with nothing outstanding");
				end else begin
					want = expected_reports.pop_front();
					if (current_index !== want.index)
						flag_mismatch($sformatf("current_index got %0d want %0d",
							current_index, want.index));
					if (current_can_announce !== want.can_announce)
						flag_mismatch($sformatf("current_can_announce got %0b want %0b",
							current_can_announce, want.can_announce));
					if (any_available !== want.any_avail)
						flag_mismatch($sformatf("any_available got %0b want %0b",
							any_available, want.any_avail));
					if (current_failures !== want.failures)
						flag_mismatch($sformatf("current_failures got %0d want %0d",
							current_failures, want.failures));
					if (current_disabled !== want.disabled)
						flag_mismatch($sformatf("current_disabled got %0b want %0b",
							current_disabled, want.disabled));
					if (current_next_allowed !== want.next_allowed)
						flag_mismatch($sformatf("current_next_allowed got %0h want %0h",
							current_next_allowed, want.next_allowed));
				end
			end

			// event beat
			if (in_valid && in_ready)
				expected_reports.push_back(advance_endpoint(action, now_seconds, interval,
					min_interval, has_min_interval, jitter_draw));
		end
	end

endmodule

// ===== sim/tb.sv =====
module tb;

	localparam int LIMIT = 400000;
	localparam int PHASE_BEATS = 150;
	localparam int DRAIN_CYCLES = 40;
	localparam int CFG_IW = abs_pkg::CFG_IDX_W;
	localparam int CFG_DW = abs_pkg::CFG_DATA_W;

	typedef struct packed {
		logic [3:0]  endpoints;
		logic [11:0] floor_s;
		logic [15:0] cap_s;
		logic [7:0]  unit_s;
		logic [3:0]  shift_cap;
		logic [3:0]  fail_limit;
	} sched_cfg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = abs_pkg::REG_NUM_ENDPOINTS;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [1:0] action = abs_pkg::ACT_QUERY;
	logic [31:0] now_seconds = '0;
	logic [31:0] interval = '0;
	logic [31:0] min_interval = '0;
	logic has_min_interval = 1'b0;
	logic signed [10:0] jitter_draw = '0;
	logic out_ready = 1'b0;

	logic in_ready;
	logic out_valid;
	logic [2:0] current_index;
	logic current_can_announce;
	logic any_available;
	logic [3:0] current_failures;
	logic current_disabled;
	logic [31:0] current_next_allowed;

	int mismatches;
	int reports_received;
	int beats_sent = 0;
	int cycle_count = 0;
	int ready_hold = 0;
	logic steady = 1'b0;
	logic [31:0] wall_clock = '0;
	sched_cfg_t plan [9];

	always #1 clk = ~clk;

	announce_backoff_scheduler_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .now_seconds(now_seconds), .interval(interval),
		.min_interval(min_interval), .has_min_interval(has_min_interval),
		.jitter_draw(jitter_draw),
		.out_valid(out_valid), .out_ready(out_ready),
		.current_index(current_index), .current_can_announce(current_can_announce),
		.any_available(any_available), .current_failures(current_failures),
		.current_disabled(current_disabled), .current_next_allowed(current_next_allowed)
	);

	announce_backoff_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .now_seconds(now_seconds), .interval(interval),
		.min_interval(min_interval), .has_min_interval(has_min_interval),
		.jitter_draw(jitter_draw),
		.out_valid(out_valid), .out_ready(out_ready),
		.current_index(current_index), .current_can_announce(current_can_announce),
		.any_available(any_available), .current_failures(current_failures),
		.current_disabled(current_disabled), .current_next_allowed(current_next_allowed),
		.mismatches(mismatches), .reports_received(reports_received)
	);

	// receiver stalls in random bursts unless steady
	always @(posedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			ready_hold = $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
			ready_hold = $urandom_range(0, 30);
		end
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input sched_cfg_t c);
		put_reg(abs_pkg::REG_NUM_ENDPOINTS, CFG_DW'(c.endpoints));
		put_reg(abs_pkg::REG_INTERVAL_FLOOR, CFG_DW'(c.floor_s));
		put_reg(abs_pkg::REG_INTERVAL_CAP, c.cap_s);
		put_reg(abs_pkg::REG_BACKOFF_UNIT, CFG_DW'(c.unit_s));
		put_reg(abs_pkg::REG_BACKOFF_SHIFT_CAP, CFG_DW'(c.shift_cap));
		put_reg(abs_pkg::REG_FAILURE_LIMIT, CFG_DW'(c.fail_limit));
		cfg_we <= 1'b0;
	endtask

	// present one event beat and hold it until taken, then maybe pause
	task automatic send_beat(
		input logic [1:0]  act,
		input logic [31:0] now,
		input logic [31:0] ivl,
		input logic [31:0] mivl,
		input logic        use_min,
		input logic [10:0] draw
	);
		action <= act;
		now_seconds <= now;
		interval <= ivl;
		min_interval <= mivl;
		has_min_interval <= use_min;
		jitter_draw <= draw;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
		if (!steady && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// lower valid and wait for every report to come back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_received != beats_sent) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_span;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 100);
			1: return $urandom_range(0, 5000);
			2: return $urandom_range(0, 70000);
			3: return $urandom();
			default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
	endfunction

	// mostly slow forward time, with jumps, wild values and the top end
	task automatic tick_wall_clock;
		case ($urandom_range(0, 15))
			0: wall_clock = $urandom();
			1: wall_clock = 32'hFFFF_FFFF - $urandom_range(0, 50);
			2, 3: wall_clock = wall_clock + $urandom_range(0, 8000);
			default: wall_clock = wall_clock + $urandom_range(0, 40);
		endcase
	endtask

	// runs of one kind of event with random content, plus mixed noise
	task automatic run_traffic(input int beats);
		int left;
		int run_len;
		int mode;
		logic [1:0] act;
		left = beats;
		while (left > 0) begin
			mode = $urandom_range(0, 9);
			run_len = (mode == 4) ? $urandom_range(1, 9) : $urandom_range(1, 20);
			if (run_len > left) run_len = left;
			for (int b = 0; b < run_len; b++) begin
				case (mode)
					0, 1: act = abs_pkg::ACT_FAILURE;
					2, 3: act = abs_pkg::ACT_SUCCESS;
					4: act = abs_pkg::ACT_ROTATE;
					default: act = 2'($urandom_range(0, 3));
				endcase
				tick_wall_clock();
				send_beat(act, wall_clock, pick_span(), pick_span(), 1'($urandom()),
					11'($urandom()));
			end
			left -= run_len;
		end
	endtask

	initial begin
		sched_cfg_t directed_cfg;

		plan[0] = '{abs_pkg::RST_NUM_ENDPOINTS, abs_pkg::RST_INTERVAL_FLOOR,
			abs_pkg::RST_INTERVAL_CAP, abs_pkg::RST_BACKOFF_UNIT,
			abs_pkg::RST_BACKOFF_SHIFT_CAP, abs_pkg::RST_FAILURE_LIMIT};
		plan[1] = '{4'd8, 12'd1, 16'd65535, 8'd255, 4'd15, 4'd15};
		plan[2] = '{4'd4, 12'd30, 16'd3600, 8'd5, 4'd10, 4'd2};
		plan[3] = '{4'd0, 12'd0, 16'd1, 8'd1, 4'd0, 4'd0};
		plan[4] = '{4'd15, 12'd3600, 16'd100, 8'd200, 4'd4, 4'd3};
		plan[5] = '{4'd3, 12'd4095, 16'd4095, 8'd0, 4'd7, 4'd15};
		plan[6] = '{4'd8, 12'd10, 16'd500, 8'd17, 4'd6, 4'd5};
		plan[7] = '{4'd2, 12'd5, 16'd60000, 8'd128, 4'd9, 4'd1};
		plan[8] = '{4'd6, 12'd60, 16'd7200, 8'd3, 4'd12, 4'd9};
		directed_cfg = '{4'd3, 12'd0, 16'd3600, 8'd5, 4'd10, 4'd1};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: three endpoints, zero floor, disable after two failures
		program_regs(directed_cfg);
		// unscheduled endpoint reads as free with a zero time
		send_beat(abs_pkg::ACT_QUERY, 32'd0, 32'd0, 32'd0, 1'b0, 11'h000);
		// zero interval with most negative draw falls back to one second
		send_beat(abs_pkg::ACT_SUCCESS, 32'd0, 32'd0, 32'd0, 1'b0, 11'h400);
		send_beat(abs_pkg::ACT_QUERY, 32'd0, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_QUERY, 32'd1, 32'd0, 32'd0, 1'b0, 11'h000);
		// draw clamped to a fifth of the interval
		send_beat(abs_pkg::ACT_SUCCESS, 32'd1000, 32'd100, 32'd0, 1'b0, 11'h3FF);
		// min interval overrides and is capped
		send_beat(abs_pkg::ACT_SUCCESS, 32'd1000, 32'd5, 32'hFFFF_FFFF, 1'b1, 11'h400);
		// time sum saturates
		send_beat(abs_pkg::ACT_SUCCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 11'h3FF);
		send_beat(abs_pkg::ACT_ROTATE, 32'd0, 32'd0, 32'd0, 1'b0, 11'h000);
		// two failures go past the limit and disable
		send_beat(abs_pkg::ACT_FAILURE, 32'd50, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_FAILURE, 32'd50, 32'd0, 32'd0, 1'b0, 11'h000);
		// success on a disabled endpoint clears failures and reschedules but leaves it disabled
		send_beat(abs_pkg::ACT_SUCCESS, 32'd100, 32'd40, 32'd0, 1'b0, 11'h155);
		send_beat(abs_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_ROTATE, 32'd0, 32'd0, 32'd0, 1'b0, 11'h000);
		// rotate wraps to the first endpoint
		send_beat(abs_pkg::ACT_ROTATE, 32'd0, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_FAILURE, 32'hFFFF_FFF0, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_SUCCESS, 32'd7, 32'hFFFF_FFFF, 32'd0, 1'b1, 11'h2AA);
		send_beat(abs_pkg::ACT_ROTATE, 32'd7, 32'd0, 32'd0, 1'b0, 11'h000);
		send_beat(abs_pkg::ACT_QUERY, 32'd8, 32'd0, 32'd0, 1'b0, 11'h000);
		drain();

		// random phases, the last one without idling
		for (int p = 0; p < 9; p++) begin
			program_regs(plan[p]);
			if (p == 8) steady = 1'b1;
			run_traffic(PHASE_BEATS);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== announce_backoff_scheduler_unit.f =====
src/abs_pkg.sv
src/abs_alu.sv
src/announce_backoff_scheduler_unit.sv
sim/announce_backoff_checker.sv
sim/tb.sv
